### rtl/ibq_pkg.sv
// Shared types, constants and helpers for the inverse bilinear quad map.
// Holds the micro-op list, the sequencer program and the controller/datapath structs.
// No dependencies.
package ibq_pkg;

    // number format and sizes
    localparam int FRAC_BITS      = 16;
    localparam int MAX_ITERATIONS = 8;
    localparam int DATA_W         = 32;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int FLOOR_W        = PROD_W - FRAC_BITS;
    localparam int ACC_W          = FLOOR_W + 4;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int NUM_REGS       = 8;
    localparam int CFG_IDX_W      = $clog2(NUM_REGS);

    // near-singular ratio and convergence tolerance
    localparam int DET_RATIO = 100000;
    localparam int RATIO_W   = $clog2(DET_RATIO + 1);
    localparam int DETK_W    = ACC_W + RATIO_W;
    localparam int TOL_RAW   = ((1 << FRAC_BITS) + 50000) / 100000;
    localparam int TOL_Q     = (TOL_RAW > 0) ? TOL_RAW : 1;
    localparam logic [PROD_W-1:0] TOL_SQ = PROD_W'(TOL_Q) * PROD_W'(TOL_Q);

    // divider: one quotient bit per cycle
    localparam int DIV_STEPS = DATA_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int INT_BITS  = DATA_W - FRAC_BITS;

    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // result status codes
    typedef enum logic [1:0] {
        STS_CONV  = 2'd0,
        STS_LIMIT = 2'd1,
        STS_DEGEN = 2'd2
    } status_t;

    // micro-ops issued by the sequencer
    typedef enum logic [5:0] {
        OP_NOP, OP_COEF, OP_D0A, OP_D0B, OP_SV_D0, OP_CHK_D0,
        OP_NSA, OP_NSB, OP_DIV0, OP_WR_S0, OP_NTA, OP_NTB, OP_WR_T0,
        OP_ST, OP_WR_ST,
        OP_SET_NRX, OP_FXA, OP_FXB, OP_FXC, OP_WR_FX,
        OP_SET_NRY, OP_FYA, OP_FYB, OP_FYC, OP_WR_FY,
        OP_SET_ESX, OP_JSXM, OP_WR_JSX,
        OP_SET_ESY, OP_JSYM, OP_WR_JSY,
        OP_SET_ETX, OP_JTXM, OP_WR_JTX,
        OP_SET_ETY, OP_JTYM, OP_WR_JTY,
        OP_DTA, OP_DTB, OP_SQX, OP_SQY, OP_WR_DET, OP_DK, OP_CHECK,
        OP_UXA, OP_UXB, OP_DIVD, OP_WR_S, OP_UYA, OP_UYB, OP_WR_T, OP_JUMP
    } op_t;

    localparam int PROG_LEN = 65;
    localparam int PC_W     = $clog2(PROG_LEN);
    localparam int LOOP_TOP = 16;

    // controller to datapath
    typedef struct packed {
        op_t     op;
        logic    take_point;
        logic    load_out;
        status_t out_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic det0_zero;
        logic conv;
        logic degen;
        logic div_done;
    } sts_t;

    // saturate a wide signed value to the word range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX)
            r = Q_MAX;
        else if (v < SAT_MIN)
            r = Q_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // sign-extend a word to accumulator width
    function automatic logic signed [ACC_W-1:0] ext(input logic signed [DATA_W-1:0] v);
        return ACC_W'(v);
    endfunction

    // sequencer program; the loop body starts at LOOP_TOP
    function automatic op_t prog_op(input logic [PC_W-1:0] pc);
        op_t r;
        case (int'(pc))
            0:  r = OP_COEF;
            1:  r = OP_D0A;
            2:  r = OP_D0B;
            3:  r = OP_NOP;
            4:  r = OP_SV_D0;
            5:  r = OP_CHK_D0;
            6:  r = OP_NSA;
            7:  r = OP_NSB;
            8:  r = OP_NOP;
            9:  r = OP_DIV0;
            10: r = OP_WR_S0;
            11: r = OP_NTA;
            12: r = OP_NTB;
            13: r = OP_NOP;
            14: r = OP_DIV0;
            15: r = OP_WR_T0;
            16: r = OP_ST;
            17: r = OP_NOP;
            18: r = OP_WR_ST;
            19: r = OP_SET_NRX;
            20: r = OP_FXA;
            21: r = OP_FXB;
            22: r = OP_FXC;
            23: r = OP_NOP;
            24: r = OP_WR_FX;
            25: r = OP_SET_NRY;
            26: r = OP_FYA;
            27: r = OP_FYB;
            28: r = OP_FYC;
            29: r = OP_NOP;
            30: r = OP_WR_FY;
            31: r = OP_SET_ESX;
            32: r = OP_JSXM;
            33: r = OP_NOP;
            34: r = OP_WR_JSX;
            35: r = OP_SET_ESY;
            36: r = OP_JSYM;
            37: r = OP_NOP;
            38: r = OP_WR_JSY;
            39: r = OP_SET_ETX;
            40: r = OP_JTXM;
            41: r = OP_NOP;
            42: r = OP_WR_JTX;
            43: r = OP_SET_ETY;
            44: r = OP_JTYM;
            45: r = OP_NOP;
            46: r = OP_WR_JTY;
            47: r = OP_DTA;
            48: r = OP_DTB;
            49: r = OP_SQX;
            50: r = OP_SQY;
            51: r = OP_WR_DET;
            52: r = OP_DK;
            53: r = OP_CHECK;
            54: r = OP_UXA;
            55: r = OP_UXB;
            56: r = OP_NOP;
            57: r = OP_DIVD;
            58: r = OP_WR_S;
            59: r = OP_UYA;
            60: r = OP_UYB;
            61: r = OP_NOP;
            62: r = OP_DIVD;
            63: r = OP_WR_T;
            64: r = OP_JUMP;
            default: r = OP_NOP;
        endcase
        return r;
    endfunction

endpackage

### rtl/inverse_bilinear_quad_map.sv
// Inverse bilinear quad map: one word in, one word out, one point at a time.
// Each point gets an affine first guess, then 0 to MAX_ITERATIONS Newton steps; a
// degenerate element (zero affine determinant) ends before the first division.
// Each division yields one quotient bit per cycle and skips the steps when it saturates.
// A new point is accepted once the last word is loaded; that word waits until taken.
// Reset (rst_n low, asynchronous) empties the block and loads the unit square vertices.
module inverse_bilinear_quad_map
    import ibq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] ref_s,
    output logic signed [DATA_W-1:0] ref_t,
    output logic [1:0]               status
);

    cmd_t cmd;
    sts_t sts;

    ibq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ibq_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point_x   (point_x),
        .point_y   (point_y),
        .cmd       (cmd),
        .sts       (sts),
        .ref_s     (ref_s),
        .ref_t     (ref_t),
        .status    (status)
    );

endmodule

### rtl/ibq_div.sv
// Restoring divider: n * 2^FRAC_BITS / d, truncated toward zero, saturated to a word.
// One quotient bit per cycle. Depends on ibq_pkg.
module ibq_div
    import ibq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  num,
    input  logic signed [ACC_W-1:0]  den,
    output logic                     done,
    output logic signed [DATA_W-1:0] quo
);

    logic              busy_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [ACC_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  ud_reg;
    logic [DATA_W-1:0] sh_reg;
    logic [DATA_W-1:0] q_reg;
    logic              neg_reg;
    logic signed [DATA_W-1:0] quo_reg;

    logic [ACC_W-1:0]  un;
    logic [ACC_W-1:0]  ud;
    logic              sat;
    logic [ACC_W:0]    trial;
    logic              ge;
    logic [ACC_W:0]    diff;
    logic [DATA_W-1:0] q_next;
    logic signed [DATA_W-1:0] q_final;

    // magnitudes and overflow test at start
    assign un  = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign ud  = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
    assign sat = (un >> INT_BITS) >= ud;

    // one restoring step
    assign trial  = {rem_reg, sh_reg[DATA_W-1]};
    assign ge     = trial >= {1'b0, ud_reg};
    assign diff   = trial - {1'b0, ud_reg};
    assign q_next = {q_reg[DATA_W-2:0], ge};

    // sign and saturation of the finished quotient
    always_comb
    begin
        if (neg_reg)
            q_final = (q_next > {1'b1, {(DATA_W-1){1'b0}}}) ? Q_MIN : -q_next;
        else
            q_final = q_next[DATA_W-1] ? Q_MAX : q_next;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !sat;
                done_reg <= sat;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[ACC_W-1] ^ den[ACC_W-1];
            ud_reg  <= ud;
            rem_reg <= un >> INT_BITS;
            sh_reg  <= {un[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            if (sat)
                quo_reg <= (num[ACC_W-1] ^ den[ACC_W-1]) ? Q_MIN : Q_MAX;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            sh_reg  <= {sh_reg[DATA_W-2:0], 1'b0};
            q_reg   <= q_next;
            if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                quo_reg <= q_final;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/ibq_datapath.sv
// Datapath: vertex registers, working registers, shared multiplier and accumulator.
// Executes one micro-op per cycle; instantiates ibq_div. Depends on ibq_pkg.
module ibq_datapath
    import ibq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic signed [DATA_W-1:0] ref_s,
    output logic signed [DATA_W-1:0] ref_t,
    output logic [1:0]               status
);

    typedef enum logic [2:0] {
        AM_NONE, AM_SET, AM_LOAD, AM_ADD, AM_SUB, AM_SQLOAD, AM_SQADD
    } am_t;

    logic signed [DATA_W-1:0] vert_reg [NUM_REGS];

    logic signed [DATA_W-1:0] px_reg, py_reg;
    logic signed [DATA_W-1:0] esx_reg, esy_reg, etx_reg, ety_reg, estx_reg, esty_reg;
    logic signed [DATA_W-1:0] rx_reg, ry_reg;
    logic signed [DATA_W-1:0] s_reg, t_reg, st_reg, fx_reg, fy_reg;
    logic signed [DATA_W-1:0] jsx_reg, jsy_reg, jtx_reg, jty_reg;
    logic signed [ACC_W-1:0]  det0_reg, det_reg, acc_reg;
    logic [ACC_W-1:0]         absd0_reg;
    logic [DETK_W-1:0]        detk_reg;
    logic [PROD_W-1:0]        nsq_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  setv_reg;
    am_t                      mode_reg;
    logic signed [DATA_W-1:0] out_s_reg, out_t_reg;
    status_t                  out_status_reg;

    logic signed [ACC_W-1:0]  x0, x1, x2, x3, y0, y1, y2, y3;
    logic signed [ACC_W-1:0]  rx_w, ry_w;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0]  setv;
    am_t                      mode;
    logic signed [ACC_W-1:0]  fl;
    logic [ACC_W-1:0]         absdet;
    logic                     div_start, div_done;
    logic signed [ACC_W-1:0]  div_den;
    logic signed [DATA_W-1:0] quo;

    // vertex registers, unit square after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_reg[0] <= '0;
            vert_reg[1] <= '0;
            vert_reg[2] <= Q_ONE;
            vert_reg[3] <= '0;
            vert_reg[4] <= Q_ONE;
            vert_reg[5] <= Q_ONE;
            vert_reg[6] <= '0;
            vert_reg[7] <= Q_ONE;
        end
        else if (cfg_we)
        begin
            vert_reg[cfg_index] <= cfg_data;
        end
    end

    // coefficient sums
    assign x0 = ext(vert_reg[0]);
    assign y0 = ext(vert_reg[1]);
    assign x1 = ext(vert_reg[2]);
    assign y1 = ext(vert_reg[3]);
    assign x2 = ext(vert_reg[4]);
    assign y2 = ext(vert_reg[5]);
    assign x3 = ext(vert_reg[6]);
    assign y3 = ext(vert_reg[7]);
    assign rx_w = (ext(px_reg) <<< 2) - (x0 + x1 + x2 + x3);
    assign ry_w = (ext(py_reg) <<< 2) - (y0 + y1 + y2 + y3);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = s_reg;
        mul_b = t_reg;
        setv  = ext(esx_reg);
        mode  = AM_NONE;
        case (cmd.op)
            OP_D0A:     begin mul_a = esx_reg;  mul_b = ety_reg; mode = AM_LOAD;   end
            OP_D0B:     begin mul_a = esy_reg;  mul_b = etx_reg; mode = AM_SUB;    end
            OP_NSA:     begin mul_a = ety_reg;  mul_b = rx_reg;  mode = AM_LOAD;   end
            OP_NSB:     begin mul_a = etx_reg;  mul_b = ry_reg;  mode = AM_SUB;    end
            OP_NTA:     begin mul_a = esx_reg;  mul_b = ry_reg;  mode = AM_LOAD;   end
            OP_NTB:     begin mul_a = esy_reg;  mul_b = rx_reg;  mode = AM_SUB;    end
            OP_ST:      begin mul_a = s_reg;    mul_b = t_reg;   mode = AM_LOAD;   end
            OP_SET_NRX: begin setv = -ext(rx_reg); mode = AM_SET; end
            OP_FXA:     begin mul_a = esx_reg;  mul_b = s_reg;   mode = AM_ADD;    end
            OP_FXB:     begin mul_a = etx_reg;  mul_b = t_reg;   mode = AM_ADD;    end
            OP_FXC:     begin mul_a = estx_reg; mul_b = st_reg;  mode = AM_ADD;    end
            OP_SET_NRY: begin setv = -ext(ry_reg); mode = AM_SET; end
            OP_FYA:     begin mul_a = esy_reg;  mul_b = s_reg;   mode = AM_ADD;    end
            OP_FYB:     begin mul_a = ety_reg;  mul_b = t_reg;   mode = AM_ADD;    end
            OP_FYC:     begin mul_a = esty_reg; mul_b = st_reg;  mode = AM_ADD;    end
            OP_SET_ESX: begin setv = ext(esx_reg); mode = AM_SET; end
            OP_JSXM:    begin mul_a = estx_reg; mul_b = t_reg;   mode = AM_ADD;    end
            OP_SET_ESY: begin setv = ext(esy_reg); mode = AM_SET; end
            OP_JSYM:    begin mul_a = esty_reg; mul_b = t_reg;   mode = AM_ADD;    end
            OP_SET_ETX: begin setv = ext(etx_reg); mode = AM_SET; end
            OP_JTXM:    begin mul_a = estx_reg; mul_b = s_reg;   mode = AM_ADD;    end
            OP_SET_ETY: begin setv = ext(ety_reg); mode = AM_SET; end
            OP_JTYM:    begin mul_a = esty_reg; mul_b = s_reg;   mode = AM_ADD;    end
            OP_DTA:     begin mul_a = jsx_reg;  mul_b = jty_reg; mode = AM_LOAD;   end
            OP_DTB:     begin mul_a = jtx_reg;  mul_b = jsy_reg; mode = AM_SUB;    end
            OP_SQX:     begin mul_a = fx_reg;   mul_b = fx_reg;  mode = AM_SQLOAD; end
            OP_SQY:     begin mul_a = fy_reg;   mul_b = fy_reg;  mode = AM_SQADD;  end
            OP_UXA:     begin mul_a = jty_reg;  mul_b = fx_reg;  mode = AM_LOAD;   end
            OP_UXB:     begin mul_a = jtx_reg;  mul_b = fy_reg;  mode = AM_SUB;    end
            OP_UYA:     begin mul_a = jsx_reg;  mul_b = fy_reg;  mode = AM_LOAD;   end
            OP_UYB:     begin mul_a = jsy_reg;  mul_b = fx_reg;  mode = AM_SUB;    end
            default:    mode = AM_NONE;
        endcase
    end

    // multiplier stage: exact product registered
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        setv_reg <= setv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= AM_NONE;
        else
            mode_reg <= mode;
    end

    // accumulate stage: floored product
    assign fl = ACC_W'(prod_reg >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        case (mode_reg)
            AM_SET:    acc_reg <= setv_reg;
            AM_LOAD:   acc_reg <= fl;
            AM_ADD:    acc_reg <= acc_reg + fl;
            AM_SUB:    acc_reg <= acc_reg - fl;
            AM_SQLOAD: nsq_reg <= prod_reg;
            AM_SQADD:  nsq_reg <= nsq_reg + prod_reg;
            default:   ;
        endcase
    end

    assign absdet = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : ACC_W'(det_reg);

    // working register writes
    always_ff @(posedge clk)
    begin
        if (cmd.take_point)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        case (cmd.op)
            OP_COEF:
            begin
                esx_reg  <= sat32(-x0 + x1 + x2 - x3);
                esy_reg  <= sat32(-y0 + y1 + y2 - y3);
                etx_reg  <= sat32(-x0 - x1 + x2 + x3);
                ety_reg  <= sat32(-y0 - y1 + y2 + y3);
                estx_reg <= sat32(x0 - x1 + x2 - x3);
                esty_reg <= sat32(y0 - y1 + y2 - y3);
                rx_reg   <= sat32(rx_w);
                ry_reg   <= sat32(ry_w);
                s_reg    <= '0;
                t_reg    <= '0;
            end
            OP_SV_D0:
            begin
                det0_reg  <= acc_reg;
                absd0_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
            end
            OP_WR_S0:  s_reg   <= quo;
            OP_WR_T0:  t_reg   <= quo;
            OP_WR_ST:  st_reg  <= sat32(acc_reg);
            OP_WR_FX:  fx_reg  <= sat32(acc_reg);
            OP_WR_FY:  fy_reg  <= sat32(acc_reg);
            OP_WR_JSX: jsx_reg <= sat32(acc_reg);
            OP_WR_JSY: jsy_reg <= sat32(acc_reg);
            OP_WR_JTX: jtx_reg <= sat32(acc_reg);
            OP_WR_JTY: jty_reg <= sat32(acc_reg);
            OP_WR_DET: det_reg <= acc_reg;
            OP_DK:     detk_reg <= DETK_W'(absdet) * DETK_W'(DET_RATIO);
            OP_WR_S:   s_reg   <= sat32(ext(s_reg) - ext(quo));
            OP_WR_T:   t_reg   <= sat32(ext(t_reg) - ext(quo));
            default:   ;
        endcase
        if (cmd.load_out)
        begin
            out_s_reg      <= s_reg;
            out_t_reg      <= t_reg;
            out_status_reg <= cmd.out_status;
        end
    end

    // shared divider; numerator is always the accumulator
    assign div_start = (cmd.op == OP_DIV0) || (cmd.op == OP_DIVD);
    assign div_den   = (cmd.op == OP_DIV0) ? det0_reg : det_reg;

    ibq_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    // status to the controller
    assign sts.det0_zero = (det0_reg == '0);
    assign sts.conv      = (nsq_reg <= TOL_SQ);
    assign sts.degen     = (detk_reg <= DETK_W'(absd0_reg));
    assign sts.div_done  = div_done;

    assign ref_s  = out_s_reg;
    assign ref_t  = out_t_reg;
    assign status = out_status_reg;

endmodule

### rtl/ibq_ctrl.sv
// Controller: sequencer over the micro-op program, Newton loop decisions, handshakes.
// Drives the datapath by cmd_t and reads sts_t. Depends on ibq_pkg.
module ibq_ctrl
    import ibq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_DIVW = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    status_t           fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;

    op_t  op_now;
    logic accept;
    logic load_out;

    assign op_now   = prog_op(pc_reg);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // commands
    always_comb
    begin
        cmd.op         = (state_reg == ST_RUN) ? op_now : OP_NOP;
        cmd.take_point = accept;
        cmd.load_out   = load_out;
        cmd.out_status = fin_reg;
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        iter_next  = iter_reg;
        fin_next   = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                    iter_next  = '0;
                end
            end
            ST_RUN:
            begin
                case (op_now)
                    OP_DIV0, OP_DIVD:
                        state_next = ST_DIVW;
                    OP_CHK_D0:
                    begin
                        if (sts.det0_zero)
                        begin
                            fin_next   = STS_DEGEN;
                            state_next = ST_FIN;
                        end
                        else
                            pc_next = pc_reg + 1'b1;
                    end
                    OP_CHECK:
                    begin
                        if (sts.conv)
                        begin
                            fin_next   = STS_CONV;
                            state_next = ST_FIN;
                        end
                        else if (sts.degen)
                        begin
                            fin_next   = STS_DEGEN;
                            state_next = ST_FIN;
                        end
                        else if (iter_reg >= ITER_W'(MAX_ITERATIONS))
                        begin
                            fin_next   = STS_LIMIT;
                            state_next = ST_FIN;
                        end
                        else
                            pc_next = pc_reg + 1'b1;
                    end
                    OP_JUMP:
                    begin
                        pc_next   = PC_W'(LOOP_TOP);
                        iter_next = iter_reg + 1'b1;
                    end
                    default:
                        pc_next = pc_reg + 1'b1;
                endcase
            end
            ST_DIVW:
            begin
                if (sts.div_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_FIN:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output word held until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            iter_reg      <= '0;
            fin_reg       <= STS_CONV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            iter_reg      <= iter_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### dv/inverse_bilinear_quad_map_test.sv
// Self-checking bench for the inverse bilinear quad map: fixed-point Newton predictor,
// queue-fed driver and clocked monitor. Depends on rtl/ibq_pkg.sv and the block's RTL.
module inverse_bilinear_quad_map_test
    import ibq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
    } point_t;

    typedef struct {
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] t;
        status_t                  sts;
    } coord_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] ref_s;
    logic signed [DATA_W-1:0] ref_t;
    logic [1:0]               status;

    inverse_bilinear_quad_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ref_s     (ref_s),
        .ref_t     (ref_t),
        .status    (status)
    );

    // bench copy of the vertex registers
    longint   vertex [NUM_REGS];
    point_t   point_q[$];
    coord_t   coord_q[$];
    int       issued_cnt;
    int       taken_cnt;
    int       err_cnt;
    bit       in_taken;
    int       send_idle_pct;
    int       recv_stall_pct;

    always #5 clk = ~clk;

    // ---------------- fixed-point predictor ----------------
    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint qdiv(longint n, longint d);
        bit                neg;
        longint unsigned   un, ud, ip, rem, q;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? longint'(-n) : n;
        ud  = (d < 0) ? longint'(-d) : d;
        ip  = un / ud;
        rem = un % ud;
        if (ip >= (64'd1 << INT_BITS))
            q = 64'd1 << 32;
        else
        begin
            q = ip;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= ud)
                begin
                    rem = rem - ud;
                    q   = q | 1;
                end
            end
        end
        if (neg)
            return (q > (64'd1 << 31)) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic coord_t map_point(point_t p);
        coord_t          r;
        longint          esx, esy, etx, ety, estx, esty, e1x, e1y, rx, ry, det0, lim;
        longint          s, t, st, fx, fy, jsx, jsy, jtx, jty, det, adet;
        longint unsigned nsq;
        bit              conv, degen;
        int              iter;
        esx  = sat_word(-vertex[0] + vertex[2] + vertex[4] - vertex[6]);
        esy  = sat_word(-vertex[1] + vertex[3] + vertex[5] - vertex[7]);
        etx  = sat_word(-vertex[0] - vertex[2] + vertex[4] + vertex[6]);
        ety  = sat_word(-vertex[1] - vertex[3] + vertex[5] + vertex[7]);
        estx = sat_word(vertex[0] - vertex[2] + vertex[4] - vertex[6]);
        esty = sat_word(vertex[1] - vertex[3] + vertex[5] - vertex[7]);
        e1x  = vertex[0] + vertex[2] + vertex[4] + vertex[6];
        e1y  = vertex[1] + vertex[3] + vertex[5] + vertex[7];
        rx   = sat_word(4 * longint'(p.px) - e1x);
        ry   = sat_word(4 * longint'(p.py) - e1y);
        det0 = qmul(esx, ety) - qmul(esy, etx);
        s    = 0;
        t    = 0;
        iter = 0;
        conv = 0;
        degen = 1;
        if (det0 != 0)
        begin
            // affine first guess, then Newton steps
            s   = qdiv(qmul(ety, rx) - qmul(etx, ry), det0);
            t   = qdiv(qmul(esx, ry) - qmul(esy, rx), det0);
            lim = ((det0 < 0) ? -det0 : det0) / DET_RATIO;
            forever
            begin
                st  = sat_word(qmul(s, t));
                fx  = sat_word(qmul(esx, s) + qmul(etx, t) + qmul(estx, st) - rx);
                fy  = sat_word(qmul(esy, s) + qmul(ety, t) + qmul(esty, st) - ry);
                jsx = sat_word(esx + qmul(estx, t));
                jsy = sat_word(esy + qmul(esty, t));
                jtx = sat_word(etx + qmul(estx, s));
                jty = sat_word(ety + qmul(esty, s));
                det = qmul(jsx, jty) - qmul(jtx, jsy);
                adet = (det < 0) ? -det : det;
                nsq = longint'(fx * fx) + longint'(fy * fy);
                conv  = nsq <= longint'(TOL_Q * TOL_Q);
                degen = adet <= lim;
                if (conv || degen || iter >= MAX_ITERATIONS)
                    break;
                s = sat_word(s - qdiv(qmul(jty, fx) - qmul(jtx, fy), det));
                t = sat_word(t - qdiv(qmul(jsx, fy) - qmul(jsy, fx), det));
                iter++;
            end
        end
        r.s   = s[DATA_W-1:0];
        r.t   = t[DATA_W-1:0];
        r.sts = conv ? STS_CONV : (degen ? STS_DEGEN : STS_LIMIT);
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    point_x  <= point_q[0].px;
                    point_y  <= point_q[0].py;
                    void'(point_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
            in_taken  = 0;
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        coord_t exp_c;
        point_t p;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                p.px = point_x;
                p.py = point_y;
                coord_q.push_back(map_point(p));
                in_taken = 1;
                taken_cnt++;
            end
            if (out_valid && !out_stall)
            begin
                if (coord_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: unexpected word s=%0d t=%0d status=%0d",
                                 ref_s, ref_t, status);
                end
                else
                begin
                    exp_c = coord_q.pop_front();
                    if (ref_s !== exp_c.s || ref_t !== exp_c.t || status !== exp_c.sts)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: s %0d/%0d t %0d/%0d status %0d/%0d (exp/act)",
                                     exp_c.s, ref_s, exp_c.t, ref_t, exp_c.sts, status);
                    end
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic push_point(longint x, longint y);
        point_t p;
        p.px = x[DATA_W-1:0];
        p.py = y[DATA_W-1:0];
        point_q.push_back(p);
        issued_cnt++;
    endtask

    // hold the sender until every expected word has come back
    task automatic drain();
        do
            @(negedge clk);
        while (taken_cnt != issued_cnt || coord_q.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_quad(longint x0, longint y0, longint x1, longint y1,
                              longint x2, longint y2, longint x3, longint y3);
        longint v [NUM_REGS];
        v = '{x0, y0, x1, y1, x2, y2, x3, y3};
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= v[i][DATA_W-1:0];
            vertex[i] = longint'(signed'(v[i][DATA_W-1:0]));
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // point on the current quad for given s,t (Q), forward bilinear map
    task automatic push_mapped(longint s, longint t);
        longint esx, esy, etx, ety, estx, esty, e1x, e1y;
        esx  = -vertex[0] + vertex[2] + vertex[4] - vertex[6];
        esy  = -vertex[1] + vertex[3] + vertex[5] - vertex[7];
        etx  = -vertex[0] - vertex[2] + vertex[4] + vertex[6];
        ety  = -vertex[1] - vertex[3] + vertex[5] + vertex[7];
        estx = vertex[0] - vertex[2] + vertex[4] - vertex[6];
        esty = vertex[1] - vertex[3] + vertex[5] - vertex[7];
        e1x  = vertex[0] + vertex[2] + vertex[4] + vertex[6];
        e1y  = vertex[1] + vertex[3] + vertex[5] + vertex[7];
        push_point(sat_word((e1x + qmul(esx, s) + qmul(etx, t) + qmul(estx, qmul(s, t))) >>> 2),
                   sat_word((e1y + qmul(esy, s) + qmul(ety, t) + qmul(esty, qmul(s, t))) >>> 2));
    endtask

    task automatic random_quad();
        longint side, cx, cy, h, j;
        side = $urandom_range(1 << 22, 1 << 14);
        cx   = longint'($urandom_range(1 << 25)) - (1 << 24);
        cy   = longint'($urandom_range(1 << 25)) - (1 << 24);
        h    = side / 2;
        j    = side / 4;
        write_quad(cx - h + $urandom_range(j), cy - h + $urandom_range(j),
                   cx + h - $urandom_range(j), cy - h + $urandom_range(j),
                   cx + h - $urandom_range(j), cy + h - $urandom_range(j),
                   cx - h + $urandom_range(j), cy + h - $urandom_range(j));
    endtask

    // ---------------- sequence ----------------
    initial
    begin
        longint qmax, qmin, one;
        int     pick;
        qmax = 64'sd2147483647;
        qmin = -64'sd2147483648;
        one  = 64'sd1 << FRAC_BITS;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        point_x = '0;
        point_y = '0;
        out_stall = 0;
        in_taken = 0;
        issued_cnt = 0;
        taken_cnt = 0;
        err_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        vertex = '{0, 0, one, 0, one, one, 0, one};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unit square from reset: corners, centre, outside, field extremes
        push_point(0, 0);
        push_point(one, one);
        push_point(one / 2, one / 2);
        push_point(2 * one, -3 * one);
        push_point(qmin, qmax);
        push_point(qmax, qmax);
        push_point(qmin, qmin);
        push_point(-1, 0);
        drain();

        // degenerate element: every vertex the same
        write_quad(one, one, one, one, one, one, one, one);
        push_point(0, 0);
        push_point(qmax, qmin);
        drain();

        // bow-tie quad: Jacobian goes singular inside
        write_quad(0, 0, one, 0, 0, one, one, one);
        push_point(one / 2, one / 2);
        push_point(one / 2, one / 4);
        push_point(one / 3, 3 * one);
        drain();

        // vertices at the register extremes; coefficients saturate
        write_quad(qmin, qmin, qmax, qmin, qmax, qmax, qmin, qmax);
        push_point(0, 0);
        push_point(qmax, qmax);
        push_point(qmin, 0);
        drain();
        write_quad(qmax, qmin, qmin, qmax, qmax, qmax, qmin, qmin);
        push_point(0, 0);
        push_point(qmax, qmin);
        drain();

        // distorted trapezoid, far points push towards the step limit
        write_quad(0, 0, 8 * one, 0, one, one / 16, 0, one);
        push_point(4 * one, one / 32);
        push_point(-100 * one, 50 * one);
        push_point(qmax, qmin);
        drain();

        // random quads, idling pattern changes with each phase
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if (ph == 7)
                write_quad($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            else
                random_quad();
            for (int n = 0; n < 200; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    push_mapped(longint'($urandom_range(2 * 78643)) - 78643,
                                longint'($urandom_range(2 * 78643)) - 78643);
                else if (pick < 90)
                    push_mapped(longint'($urandom_range(16 * one)) - 8 * one,
                                longint'($urandom_range(16 * one)) - 8 * one);
                else
                    push_point(longint'(signed'($urandom)), longint'(signed'($urandom)));
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
